// ===== hdl/wcpr_pkg.sv =====
// shared types, constants and register codes of the window compositor pixel resolver
package wcpr_pkg;

    // default sizing
    localparam int unsigned VIEW_SLOTS_DEF = 8;
    localparam int unsigned COORD_BITS_DEF = 12;

    // stream widths
    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned S_TUSER_W = 1;
    localparam int unsigned M_TDATA_W = 56;
    localparam int unsigned M_TUSER_W = 2;

    // configuration port
    localparam int unsigned APB_AW = 4;
    localparam int unsigned APB_DW = 32;

    // background shading
    localparam int unsigned EDGE_FADE    = 64;
    // x / 30 == (x * 2185) >> 16 for 0 <= x < 4096
    localparam int unsigned RECIP_CHECKER = 2185;
    localparam int unsigned CHECKER_SHIFT = 16;
    // f / 5 == (f * 205) >> 10 for 0 <= f <= 64
    localparam int unsigned RECIP_FIVE    = 205;
    localparam int unsigned FIVE_SHIFT    = 10;
    // d / 3 == (d * 43691) >> 17 for 0 <= d < 16384
    localparam int unsigned RECIP_THREE   = 43691;
    localparam int unsigned THREE_SHIFT   = 17;

    // register reset values
    localparam logic [23:0] RST_FIRST_COLOUR  = 24'h202020;
    localparam logic [23:0] RST_SECOND_COLOUR = 24'h282828;
    localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd1024;
    localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd768;

    // register index codes
    typedef enum logic [1:0] {
        REG_FIRST_COLOUR  = 2'd0,
        REG_SECOND_COLOUR = 2'd1,
        REG_SCREEN_WIDTH  = 2'd2,
        REG_SCREEN_HEIGHT = 2'd3
    } wcpr_reg_t;

    // item kinds
    localparam logic KIND_QUERY = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // one input beat
    typedef struct packed {
        logic               kind;
        logic signed [12:0] pos_x;
        logic signed [12:0] pos_y;
        logic [2:0]         slot;
        logic [11:0]        win_width;
        logic [11:0]        win_height;
        logic [2:0]         win_scale;
        logic               win_visible;
    } wcpr_item_t;

    // configuration registers
    typedef struct packed {
        logic [23:0] first_colour;
        logic [23:0] second_colour;
        logic [12:0] screen_width;
        logic [12:0] screen_height;
    } wcpr_cfg_t;

    // stage control
    typedef struct packed {
        logic load;
        logic vld;
    } wcpr_ctl_t;

    // after window lookup
    typedef struct packed {
        logic        covered;
        logic        off_screen;
        logic [2:0]  top_slot;
        logic [13:0] dx;
        logic [13:0] dy;
        logic [2:0]  scale;
        logic [11:0] px;
        logic [11:0] py;
    } wcpr_hit_t;

    // after scale division and fade
    typedef struct packed {
        logic        covered;
        logic        off_screen;
        logic [2:0]  top_slot;
        logic [11:0] source_x;
        logic [11:0] source_y;
        logic [3:0]  shade;
        logic [11:0] px;
        logic [11:0] py;
    } wcpr_src_t;

    // one result beat
    typedef struct packed {
        logic        covered;
        logic        off_screen;
        logic [2:0]  top_slot;
        logic [11:0] source_x;
        logic [11:0] source_y;
        logic [23:0] colour;
    } wcpr_res_t;

endpackage

// ===== hdl/wcpr_apb_regs.sv =====
// apb configuration registers: checker colours and screen size
module wcpr_apb_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wcpr_pkg::APB_AW-1:0]    paddr,
    input  logic [wcpr_pkg::APB_DW-1:0]    pwdata,
    output logic [wcpr_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    output wcpr_pkg::wcpr_cfg_t            cfg
);
    import wcpr_pkg::*;

    wcpr_cfg_t cfg_reg;
    wcpr_cfg_t cfg_next;
    wcpr_reg_t reg_idx;
    logic      wr_en;

    assign pready  = 1'b1;
    assign reg_idx = wcpr_reg_t'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite & pready;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_FIRST_COLOUR:  cfg_next.first_colour  = pwdata[23:0];
                REG_SECOND_COLOUR: cfg_next.second_colour = pwdata[23:0];
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = pwdata[12:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height = pwdata[12:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_colour  <= RST_FIRST_COLOUR;
            cfg_reg.second_colour <= RST_SECOND_COLOUR;
            cfg_reg.screen_width  <= RST_SCREEN_WIDTH;
            cfg_reg.screen_height <= RST_SCREEN_HEIGHT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read back
    always_comb begin
        unique case (reg_idx)
            REG_FIRST_COLOUR:  prdata = APB_DW'(cfg_reg.first_colour);
            REG_SECOND_COLOUR: prdata = APB_DW'(cfg_reg.second_colour);
            REG_SCREEN_WIDTH:  prdata = APB_DW'(cfg_reg.screen_width);
            REG_SCREEN_HEIGHT: prdata = APB_DW'(cfg_reg.screen_height);
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/wcpr_view_table.sv =====
// view table storage, slot writes and topmost-window lookup stage
module wcpr_view_table #(
    parameter int unsigned VIEW_SLOTS = wcpr_pkg::VIEW_SLOTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wcpr_pkg::wcpr_ctl_t  ctl,
    input  wcpr_pkg::wcpr_item_t item,
    input  wcpr_pkg::wcpr_cfg_t  cfg,
    output wcpr_pkg::wcpr_hit_t  hit
);
    import wcpr_pkg::*;

    // per-slot geometry, extents precomputed at write time
    logic signed [12:0] left_reg   [VIEW_SLOTS];
    logic signed [12:0] top_reg    [VIEW_SLOTS];
    logic signed [16:0] right_reg  [VIEW_SLOTS];
    logic signed [16:0] bottom_reg [VIEW_SLOTS];
    logic [2:0]         scale_reg  [VIEW_SLOTS];
    // shown and scale in 1..4
    logic [VIEW_SLOTS-1:0] live_reg;
    logic [VIEW_SLOTS-1:0] live_next;

    wcpr_hit_t hit_reg;
    wcpr_hit_t hit_next;

    logic               wr_en;
    logic               wr_live;
    logic signed [16:0] wr_right;
    logic signed [16:0] wr_bottom;
    logic signed [16:0] x_ext;
    logic signed [16:0] y_ext;
    logic               off;

    assign wr_en   = ctl.load & ctl.vld & (item.kind == KIND_WRITE);
    assign wr_live = item.win_visible & (item.win_scale >= 3'd1) & (item.win_scale <= 3'd4);

    // window extent: left + width * scale, top + height * scale
    assign wr_right  = 17'($signed(item.pos_x))
                     + $signed({2'b00, 15'(15'(item.win_width) * 15'(item.win_scale))});
    assign wr_bottom = 17'($signed(item.pos_y))
                     + $signed({2'b00, 15'(15'(item.win_height) * 15'(item.win_scale))});

    // shown bits
    always_comb begin
        live_next = live_reg;
        for (int i = 0; i < VIEW_SLOTS; i++) begin
            if (wr_en && (6'(item.slot) == 6'(i))) begin
                live_next[i] = wr_live;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= '0;
        end else begin
            live_reg <= live_next;
        end
    end

    // geometry, no reset
    always_ff @(posedge aclk) begin
        for (int i = 0; i < VIEW_SLOTS; i++) begin
            if (wr_en && (6'(item.slot) == 6'(i))) begin
                left_reg[i]   <= item.pos_x;
                top_reg[i]    <= item.pos_y;
                right_reg[i]  <= wr_right;
                bottom_reg[i] <= wr_bottom;
                scale_reg[i]  <= item.win_scale;
            end
        end
    end

    // screen clipping
    assign x_ext = 17'($signed(item.pos_x));
    assign y_ext = 17'($signed(item.pos_y));
    assign off   = (x_ext < 17'sd0) || (y_ext < 17'sd0)
                || (x_ext >= $signed({4'b0000, cfg.screen_width}))
                || (y_ext >= $signed({4'b0000, cfg.screen_height}));

    // compare every slot, highest covering slot wins
    always_comb begin
        logic               any;
        logic [2:0]         sel_slot;
        logic [13:0]        sel_dx;
        logic [13:0]        sel_dy;
        logic [2:0]         sel_scale;
        logic signed [16:0] l_ext;
        logic signed [16:0] t_ext;
        any       = 1'b0;
        sel_slot  = '0;
        sel_dx    = '0;
        sel_dy    = '0;
        sel_scale = '0;
        for (int i = 0; i < VIEW_SLOTS; i++) begin
            l_ext = 17'(left_reg[i]);
            t_ext = 17'(top_reg[i]);
            if (live_reg[i] && (x_ext >= l_ext) && (y_ext >= t_ext)
                && (x_ext < right_reg[i]) && (y_ext < bottom_reg[i])) begin
                any       = 1'b1;
                sel_slot  = 3'(i);
                sel_dx    = 14'(x_ext - l_ext);
                sel_dy    = 14'(y_ext - t_ext);
                sel_scale = scale_reg[i];
            end
        end
        hit_next.covered    = any & ~off;
        hit_next.off_screen = off;
        hit_next.top_slot   = (any & ~off) ? sel_slot : 3'd0;
        hit_next.dx         = sel_dx;
        hit_next.dy         = sel_dy;
        hit_next.scale      = sel_scale;
        hit_next.px         = item.pos_x[11:0];
        hit_next.py         = item.pos_y[11:0];
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

// ===== hdl/wcpr_scale_fade.sv =====
// source coordinate division by window scale and edge fade amount
module wcpr_scale_fade #(
    parameter int unsigned COORD_BITS = wcpr_pkg::COORD_BITS_DEF
) (
    input  logic                aclk,
    input  logic                load,
    input  wcpr_pkg::wcpr_hit_t hit,
    input  wcpr_pkg::wcpr_cfg_t cfg,
    output wcpr_pkg::wcpr_src_t src
);
    import wcpr_pkg::*;

    localparam logic [11:0] SRC_MASK = 12'((64'(1) << COORD_BITS) - 64'(1));

    wcpr_src_t src_reg;
    wcpr_src_t src_next;

    logic [29:0] third_x;
    logic [29:0] third_y;
    logic [13:0] qx;
    logic [13:0] qy;
    logic [12:0] px_far;
    logic [6:0]  fade;
    logic [14:0] fade_prod;

    // divide by three through a reciprocal
    assign third_x = 30'(hit.dx) * 30'(RECIP_THREE);
    assign third_y = 30'(hit.dy) * 30'(RECIP_THREE);

    // scales one to four, shifts for the powers of two
    always_comb begin
        unique case (hit.scale)
            3'd1:    begin qx = hit.dx;                   qy = hit.dy;                   end
            3'd2:    begin qx = hit.dx >> 1;              qy = hit.dy >> 1;              end
            3'd3:    begin qx = 14'(third_x >> THREE_SHIFT); qy = 14'(third_y >> THREE_SHIFT); end
            3'd4:    begin qx = hit.dx >> 2;              qy = hit.dy >> 2;              end
            default: begin qx = '0;                       qy = '0;                       end
        endcase
    end

    // left edge wins over right edge on a narrow screen
    assign px_far = 13'(hit.px) + 13'(EDGE_FADE);
    always_comb begin
        if (hit.px < 12'(EDGE_FADE)) begin
            fade = 7'(13'(EDGE_FADE) - 13'(hit.px));
        end else if (px_far >= cfg.screen_width) begin
            fade = 7'(px_far - cfg.screen_width);
        end else begin
            fade = '0;
        end
    end

    assign fade_prod = 15'(fade) * 15'(RECIP_FIVE);

    always_comb begin
        src_next.covered    = hit.covered;
        src_next.off_screen = hit.off_screen;
        src_next.top_slot   = hit.top_slot;
        src_next.source_x   = hit.covered ? (12'(qx) & SRC_MASK) : 12'd0;
        src_next.source_y   = hit.covered ? (12'(qy) & SRC_MASK) : 12'd0;
        src_next.shade      = 4'(fade_prod >> FIVE_SHIFT);
        src_next.px         = hit.px;
        src_next.py         = hit.py;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            src_reg <= src_next;
        end
    end

    assign src = src_reg;

endmodule

// ===== hdl/wcpr_shade_out.sv =====
// checkerboard colour pick, channel darkening and result register
module wcpr_shade_out (
    input  logic                aclk,
    input  logic                load,
    input  wcpr_pkg::wcpr_src_t src,
    input  wcpr_pkg::wcpr_cfg_t cfg,
    output wcpr_pkg::wcpr_res_t res
);
    import wcpr_pkg::*;

    wcpr_res_t res_reg;
    wcpr_res_t res_next;

    logic [23:0] prod_x;
    logic [23:0] prod_y;
    logic        odd;
    logic [23:0] base;
    logic [23:0] dark;

    // parity of x / 30 + y / 30
    assign prod_x = 24'(src.px) * 24'(RECIP_CHECKER);
    assign prod_y = 24'(src.py) * 24'(RECIP_CHECKER);
    assign odd    = prod_x[CHECKER_SHIFT] ^ prod_y[CHECKER_SHIFT];
    assign base   = odd ? cfg.first_colour : cfg.second_colour;

    // per channel subtract with clamp at zero
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            if (base[8*ch +: 8] > 8'(src.shade)) begin
                dark[8*ch +: 8] = base[8*ch +: 8] - 8'(src.shade);
            end else begin
                dark[8*ch +: 8] = 8'd0;
            end
        end
    end

    always_comb begin
        res_next.covered    = src.covered;
        res_next.off_screen = src.off_screen;
        res_next.top_slot   = src.top_slot;
        res_next.source_x   = src.source_x;
        res_next.source_y   = src.source_y;
        res_next.colour     = (src.covered | src.off_screen) ? 24'd0 : dark;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== hdl/window_compositor_pixel_resolve_top.sv =====
// top level of the window compositor pixel resolver: stream ports, apb port, pipeline control
//
// Resolves screen pixels against a stack of up to VIEW_SLOTS windows, higher slots on top.
// A beat with tuser kind set writes one view table slot and gives no result; any other beat
// is a pixel query and gives exactly one result beat: the topmost covering window with the
// source column and row divided by its scale, or otherwise the shaded checkerboard colour,
// or the off-screen flag. The block takes one beat every clock cycle unless a stalled result
// backs up the pipe, and a query passes four register stages (input, window lookup, scale
// division and fade, colour and output). Ready travels back through the stages in the same
// cycle, so a stalled result holds the pipe without loss. A slot write takes effect for every
// query that follows it on the input. The user is to write configuration registers over apb
// while the block is idle; the block does not enforce it. Register i sits at byte address 4*i.
module window_compositor_pixel_resolve_top #(
    parameter int unsigned VIEW_SLOTS = wcpr_pkg::VIEW_SLOTS_DEF,
    parameter int unsigned COORD_BITS = wcpr_pkg::COORD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pos_x[12:0], pos_y[25:13], slot[28:26], win_width[40:29], win_height[52:41],
    // win_scale[55:53], win_visible[56], zero fill[63:57]
    input  logic [wcpr_pkg::S_TDATA_W-1:0]    s_tdata,
    // kind[0]
    input  logic [wcpr_pkg::S_TUSER_W-1:0]    s_tuser,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // top_slot[2:0], source_x[14:3], source_y[26:15], colour[50:27], zero fill[55:51]
    output logic [wcpr_pkg::M_TDATA_W-1:0]    m_tdata,
    // covered[0], off_screen[1]
    output logic [wcpr_pkg::M_TUSER_W-1:0]    m_tuser,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wcpr_pkg::APB_AW-1:0]       paddr,
    input  logic [wcpr_pkg::APB_DW-1:0]       pwdata,
    output logic [wcpr_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);
    import wcpr_pkg::*;

    wcpr_cfg_t  cfg;
    wcpr_item_t in_item;
    wcpr_item_t item_reg;
    wcpr_hit_t  hit;
    wcpr_src_t  src;
    wcpr_res_t  res;
    wcpr_ctl_t  lookup_ctl;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;

    // configuration registers
    wcpr_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // unpack the input beat
    always_comb begin
        in_item.kind        = s_tuser[0];
        in_item.pos_x       = s_tdata[12:0];
        in_item.pos_y       = s_tdata[25:13];
        in_item.slot        = s_tdata[28:26];
        in_item.win_width   = s_tdata[40:29];
        in_item.win_height  = s_tdata[52:41];
        in_item.win_scale   = s_tdata[55:53];
        in_item.win_visible = s_tdata[56];
    end

    // stage ready chain, a stage advances when it is empty or the next one moves
    assign rdy4     = m_tready | ~v4_reg;
    assign rdy3     = rdy4 | ~v3_reg;
    assign rdy2     = rdy3 | ~v2_reg;
    assign rdy1     = rdy2 | ~v1_reg;
    assign s_tready = rdy1;

    // valid bits; slot writes end at the lookup stage
    assign v1_next = rdy1 ? s_tvalid : v1_reg;
    assign v2_next = rdy2 ? (v1_reg & (item_reg.kind == KIND_QUERY)) : v2_reg;
    assign v3_next = rdy3 ? v2_reg : v3_reg;
    assign v4_next = rdy4 ? v3_reg : v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            item_reg <= in_item;
        end
    end

    // window lookup stage, also commits slot writes in order
    assign lookup_ctl.load = rdy2;
    assign lookup_ctl.vld  = v1_reg;

    wcpr_view_table #(
        .VIEW_SLOTS (VIEW_SLOTS)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (lookup_ctl),
        .item    (item_reg),
        .cfg     (cfg),
        .hit     (hit)
    );

    // scale division and fade stage
    wcpr_scale_fade #(
        .COORD_BITS (COORD_BITS)
    ) u_scale (
        .aclk (aclk),
        .load (rdy3),
        .hit  (hit),
        .cfg  (cfg),
        .src  (src)
    );

    // colour and output stage
    wcpr_shade_out u_shade (
        .aclk (aclk),
        .load (rdy4),
        .src  (src),
        .cfg  (cfg),
        .res  (res)
    );

    // pack the result beat
    assign m_tvalid = v4_reg;
    assign m_tdata  = {5'd0, res.colour, res.source_y, res.source_x, res.top_slot};
    assign m_tuser  = {res.off_screen, res.covered};

endmodule

// ===== test/tb_window_compositor_pixel_resolve_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the window compositor pixel resolver: stream and apb stimulus
module tb_window_compositor_pixel_resolve_top;
    import wcpr_pkg::*;

    localparam int SLOTS       = 8;
    localparam int HALF_PERIOD = 5;
    localparam int PIPE_DEPTH  = 4;
    localparam int SETTLE      = 3 * PIPE_DEPTH;
    localparam int STALL_LIMIT = 3000;
    localparam int FADE_SPAN   = 64;
    localparam int CHECK_SIZE  = 30;
    localparam int FADE_STEP   = 5;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // predicted view table and registers
    int          win_left [SLOTS];
    int          win_top  [SLOTS];
    int          win_w    [SLOTS];
    int          win_h    [SLOTS];
    int          win_k    [SLOTS];
    bit          win_on   [SLOTS];
    logic [23:0] bg_odd  = 24'h202020;
    logic [23:0] bg_even = 24'h282828;
    int          scr_w   = 1024;
    int          scr_h   = 768;

    // geometry as last queued, used to aim queries at windows
    int gen_left [SLOTS];
    int gen_top  [SLOTS];
    int gen_w    [SLOTS];
    int gen_h    [SLOTS];
    int gen_k    [SLOTS];

    wcpr_item_t pending_beats[$];
    wcpr_res_t  expected_pixels[$];
    wcpr_item_t cur_beat;
    wcpr_res_t  got_pixel;
    wcpr_res_t  want_pixel;

    bit beat_taken  = 1'b0;
    int burst_left  = 1;
    int gap_left    = 0;
    int rx_cycle    = 0;
    int stall_run   = 0;
    int idle_cycles = 0;
    int fault_count = 0;

    window_compositor_pixel_resolve_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #HALF_PERIOD aclk = ~aclk;

    task automatic report_fault(string what);
        $display("ERROR at %0t: %s", $time, what);
        fault_count++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want) begin
            report_fault($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    // expected result of one pixel query against the current view table
    function automatic wcpr_res_t resolve_pixel(int x, int y);
        wcpr_res_t   px;
        logic [23:0] base;
        int          sc, dx, dy, fade, cut, chan;
        px = '0;
        if (x < 0 || y < 0 || x >= scr_w || y >= scr_h) begin
            px.off_screen = 1'b1;
            return px;
        end
        // topmost shown window with a usable scale wins
        for (int s = SLOTS - 1; s >= 0; s--) begin
            sc = win_k[s];
            dx = x - win_left[s];
            dy = y - win_top[s];
            if (!px.covered && win_on[s] && sc >= 1 && sc <= 4 && dx >= 0 && dy >= 0
                    && dx < win_w[s] * sc && dy < win_h[s] * sc) begin
                px.covered  = 1'b1;
                px.top_slot = 3'(s);
                px.source_x = 12'(dx / sc);
                px.source_y = 12'(dy / sc);
            end
        end
        if (px.covered) begin
            return px;
        end
        // checkerboard, darkened toward the side edges, left edge first
        base = (((x / CHECK_SIZE) + (y / CHECK_SIZE)) % 2 != 0) ? bg_odd : bg_even;
        if (x < FADE_SPAN) begin
            fade = FADE_SPAN - x;
        end else if (x >= scr_w - FADE_SPAN) begin
            fade = FADE_SPAN - (scr_w - x);
        end else begin
            fade = 0;
        end
        cut = fade / FADE_STEP;
        for (int c = 0; c < 3; c++) begin
            chan = base[8*c +: 8];
            px.colour[8*c +: 8] = (chan > cut) ? 8'(chan - cut) : 8'd0;
        end
        return px;
    endfunction

    task automatic push_write(int slot, int x, int y, int w, int h, int k, bit vis);
        wcpr_item_t b;
        b.kind        = KIND_WRITE;
        b.pos_x       = 13'(x);
        b.pos_y       = 13'(y);
        b.slot        = 3'(slot);
        b.win_width   = 12'(w);
        b.win_height  = 12'(h);
        b.win_scale   = 3'(k);
        b.win_visible = vis;
        pending_beats.insert(pending_beats.size(), b);
        gen_left[b.slot] = $signed(b.pos_x);
        gen_top[b.slot]  = $signed(b.pos_y);
        gen_w[b.slot]    = b.win_width;
        gen_h[b.slot]    = b.win_height;
        gen_k[b.slot]    = b.win_scale;
    endtask

    // fields a query ignores carry random bits
    task automatic push_query(int x, int y);
        wcpr_item_t b;
        b.kind        = KIND_QUERY;
        b.pos_x       = 13'(x);
        b.pos_y       = 13'(y);
        b.slot        = 3'($urandom);
        b.win_width   = 12'($urandom);
        b.win_height  = 12'($urandom);
        b.win_scale   = 3'($urandom);
        b.win_visible = 1'($urandom);
        pending_beats.insert(pending_beats.size(), b);
    endtask

    task automatic add_random(int n);
        int pick, s, k, span_w, span_h;
        span_w = (scr_w > 0) ? scr_w : 1;
        span_h = (scr_h > 0) ? scr_h : 1;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                // window around the screen, now and then with a bad scale
                k = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) % 8
                                                : $urandom_range(1, 4);
                push_write($urandom_range(0, SLOTS - 1),
                           int'($urandom_range(0, span_w + 64)) - 64,
                           int'($urandom_range(0, span_h + 64)) - 64,
                           $urandom_range(0, 120), $urandom_range(0, 120), k,
                           $urandom_range(0, 3) != 0);
            end else if (pick < 16) begin
                // any geometry the fields allow
                push_write($urandom_range(0, SLOTS - 1),
                           int'($urandom_range(0, 8191)) - 4096,
                           int'($urandom_range(0, 8191)) - 4096,
                           $urandom_range(0, 4095), $urandom_range(0, 4095),
                           $urandom_range(0, 7), $urandom_range(0, 1));
            end else if (pick < 62) begin
                // aim at a window, its borders included
                s = $urandom_range(0, SLOTS - 1);
                k = (gen_k[s] >= 1 && gen_k[s] <= 4) ? gen_k[s] : 1;
                push_query(gen_left[s] + int'($urandom_range(0, gen_w[s] * k + 1)) - 1,
                           gen_top[s] + int'($urandom_range(0, gen_h[s] * k + 1)) - 1);
            end else if (pick < 74) begin
                // edge fade bands
                if ($urandom_range(0, 1) == 0) begin
                    push_query($urandom_range(0, 70), $urandom_range(0, span_h));
                end else begin
                    push_query(span_w - 1 - int'($urandom_range(0, 70)),
                               $urandom_range(0, span_h));
                end
            end else if (pick < 94) begin
                push_query(int'($urandom_range(0, span_w + 3)) - 2,
                           int'($urandom_range(0, span_h + 3)) - 2);
            end else begin
                push_query(int'($urandom_range(0, 8191)) - 4096,
                           int'($urandom_range(0, 8191)) - 4096);
            end
        end
    endtask

    task automatic apb_access(input logic wr, input wcpr_reg_t r, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {r, 2'b00};
        pwdata  = wdata;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_reg(wcpr_reg_t r, logic [31:0] want);
        logic [31:0] rdata;
        apb_access(1'b0, r, '0, rdata);
        if (rdata != want) begin
            report_fault($sformatf("register %s reads %0h, expected %0h", r.name(),
                                   rdata, want));
        end
    endtask

    task automatic set_reg(wcpr_reg_t r, logic [31:0] v);
        logic [31:0] rdata;
        logic [31:0] held;
        apb_access(1'b1, r, v, rdata);
        case (r)
            REG_FIRST_COLOUR: begin
                bg_odd = v[23:0];
                held   = {8'd0, v[23:0]};
            end
            REG_SECOND_COLOUR: begin
                bg_even = v[23:0];
                held    = {8'd0, v[23:0]};
            end
            REG_SCREEN_WIDTH: begin
                scr_w = v[12:0];
                held  = {19'd0, v[12:0]};
            end
            default: begin
                scr_h = v[12:0];
                held  = {19'd0, v[12:0]};
            end
        endcase
        check_reg(r, held);
    endtask

    // wait for the pipe to empty, then let trailing slot writes drain
    task automatic settle_pipe();
        while (pending_beats.size() != 0 || s_tvalid || expected_pixels.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    // input beats: bursts of random length with random gaps
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || beat_taken)) begin
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
                cur_beat = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, cur_beat.win_visible, cur_beat.win_scale,
                             cur_beat.win_height, cur_beat.win_width, cur_beat.slot,
                             cur_beat.pos_y, cur_beat.pos_x};
                s_tuser  <= cur_beat.kind;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end

        // result side stalls, cycling through four patterns
        rx_cycle++;
        case ((rx_cycle / 256) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_cycle % 5) != 0;
            default: begin
                if (stall_run > 0) begin
                    stall_run--;
                    m_tready <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    stall_run = $urandom_range(4, 40);
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    // result check, input capture with prediction, and stall watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got_pixel.covered    = m_tuser[0];
                got_pixel.off_screen = m_tuser[1];
                got_pixel.top_slot   = m_tdata[2:0];
                got_pixel.source_x   = m_tdata[14:3];
                got_pixel.source_y   = m_tdata[26:15];
                got_pixel.colour     = m_tdata[50:27];
                if (expected_pixels.size() == 0) begin
                    report_fault("result beat with no query outstanding");
                end else begin
                    want_pixel = expected_pixels.pop_front();
                    check_field("covered", got_pixel.covered, want_pixel.covered);
                    check_field("off_screen", got_pixel.off_screen, want_pixel.off_screen);
                    check_field("top_slot", got_pixel.top_slot, want_pixel.top_slot);
                    check_field("source_x", got_pixel.source_x, want_pixel.source_x);
                    check_field("source_y", got_pixel.source_y, want_pixel.source_y);
                    check_field("colour", got_pixel.colour, want_pixel.colour);
                end
            end

            beat_taken = s_tvalid && s_tready;
            if (beat_taken) begin
                if (cur_beat.kind == KIND_WRITE) begin
                    win_left[cur_beat.slot] = $signed(cur_beat.pos_x);
                    win_top[cur_beat.slot]  = $signed(cur_beat.pos_y);
                    win_w[cur_beat.slot]    = cur_beat.win_width;
                    win_h[cur_beat.slot]    = cur_beat.win_height;
                    win_k[cur_beat.slot]    = cur_beat.win_scale;
                    win_on[cur_beat.slot]   = cur_beat.win_visible;
                end else begin
                    expected_pixels.insert(expected_pixels.size(),
                                           resolve_pixel($signed(cur_beat.pos_x),
                                                         $signed(cur_beat.pos_y)));
                end
            end

            if (beat_taken || (m_tvalid && m_tready) || (psel && penable)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            win_left[s] = 0;
            win_top[s]  = 0;
            win_w[s]    = 0;
            win_h[s]    = 0;
            win_k[s]    = 0;
            win_on[s]   = 1'b0;
            gen_left[s] = 0;
            gen_top[s]  = 0;
            gen_w[s]    = 0;
            gen_h[s]    = 0;
            gen_k[s]    = 0;
        end
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // register values after reset
        check_reg(REG_FIRST_COLOUR, 32'h202020);
        check_reg(REG_SECOND_COLOUR, 32'h282828);
        check_reg(REG_SCREEN_WIDTH, 32'd1024);
        check_reg(REG_SCREEN_HEIGHT, 32'd768);

        // background corners, edge fade, checker borders, off screen
        push_query(0, 0);
        push_query(63, 29);
        push_query(64, 30);
        push_query(959, 0);
        push_query(960, 0);
        push_query(1023, 767);
        push_query(-1, 0);
        push_query(0, -1);
        push_query(1024, 0);
        push_query(0, 768);
        push_query(-4096, -4096);
        push_query(4095, 4095);
        // full-screen window at the bottom, small scaled window on top
        push_write(0, -4096, -4096, 4095, 4095, 4, 1'b1);
        push_query(500, 300);
        push_write(7, 100, 100, 10, 10, 2, 1'b1);
        push_query(100, 100);
        push_query(119, 119);
        push_query(120, 100);
        // unsupported scales and an empty window cover nothing
        push_write(6, 0, 0, 4095, 4095, 0, 1'b1);
        push_write(5, 0, 0, 4095, 4095, 5, 1'b1);
        push_write(4, 0, 0, 0, 100, 1, 1'b1);
        push_query(5, 5);
        // hidden window falls through to the one below
        push_write(7, 100, 100, 10, 10, 2, 1'b0);
        push_query(100, 100);
        push_write(0, 0, 0, 1, 1, 1, 1'b0);
        settle_pipe();

        add_random(140);
        settle_pipe();

        // colour extremes, largest screen
        set_reg(REG_FIRST_COLOUR, 32'h000000);
        set_reg(REG_SECOND_COLOUR, 32'hffffff);
        set_reg(REG_SCREEN_WIDTH, 32'd4096);
        set_reg(REG_SCREEN_HEIGHT, 32'd4096);
        add_random(140);
        settle_pipe();

        // narrow screen where both edge bands overlap
        set_reg(REG_FIRST_COLOUR, {8'd0, 24'($urandom)});
        set_reg(REG_SECOND_COLOUR, {8'd0, 24'($urandom)});
        set_reg(REG_SCREEN_WIDTH, 32'd100);
        set_reg(REG_SCREEN_HEIGHT, 32'd60);
        add_random(120);
        settle_pipe();

        // one-pixel screen
        set_reg(REG_SCREEN_WIDTH, 32'd1);
        set_reg(REG_SCREEN_HEIGHT, 32'd1);
        add_random(40);
        settle_pipe();

        // empty screen, every pixel off screen
        set_reg(REG_SCREEN_WIDTH, 32'd0);
        set_reg(REG_SCREEN_HEIGHT, 32'd0);
        add_random(20);
        settle_pipe();

        // random setting
        set_reg(REG_FIRST_COLOUR, {8'd0, 24'($urandom)});
        set_reg(REG_SECOND_COLOUR, {8'd0, 24'($urandom)});
        set_reg(REG_SCREEN_WIDTH, $urandom_range(64, 4096));
        set_reg(REG_SCREEN_HEIGHT, $urandom_range(1, 4096));
        add_random(140);
        settle_pipe();

        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
